### rtl/lfope_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfope_pkg
// Types, constants and the control store of the LFO / portamento engine.
// ----------------------------------------------------------------------------
package lfope_pkg;

    localparam int CHANNELS   = 16;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CMP_W   = 7;

    localparam logic [15:0] GLIDE_IDLE = 16'hffff;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;
    localparam logic [15:0] MIN_PERIOD = 16'd4;

    // floor(x / 100) as (x * MAG_RECIP) >> MAG_SHIFT, exact for x up to 100 * 127
    localparam logic [12:0] MAG_RECIP  = 13'd5243;
    localparam int          MAG_SHIFT  = 19;

    localparam int DIV_W     = 23;
    localparam int DIV_CNT_W = 5;
    localparam int UPC_W     = 5;

    // pitch actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_GLIDE   = 2'd2;
    localparam logic [1:0] ACT_VIBRATO = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_DIV_POS   = 4'd1;
    localparam logic [3:0] OP_SAVE_POS  = 4'd2;
    localparam logic [3:0] OP_HALF      = 4'd3;
    localparam logic [3:0] OP_DIV_QTR   = 4'd4;
    localparam logic [3:0] OP_DIV_INQ   = 4'd5;
    localparam logic [3:0] OP_MUL_MAG   = 4'd6;
    localparam logic [3:0] OP_SAVE_LFO  = 4'd7;
    localparam logic [3:0] OP_GLIDE     = 4'd8;
    localparam logic [3:0] OP_DIV_PCT   = 4'd9;
    localparam logic [3:0] OP_SAVE_PCT  = 4'd10;
    localparam logic [3:0] OP_EMIT      = 4'd11;
    localparam logic [3:0] OP_EMIT_ZERO = 4'd12;

    // sequencing conditions
    localparam logic [2:0] C_NEXT       = 3'd0;
    localparam logic [2:0] C_WAIT_DIV   = 3'd1;
    localparam logic [2:0] C_BAD_CH     = 3'd2;
    localparam logic [2:0] C_LFO_OFF    = 3'd3;
    localparam logic [2:0] C_GLIDE_SKIP = 3'd4;
    localparam logic [2:0] C_OUT_WAIT   = 3'd5;
    localparam logic [2:0] C_END        = 3'd6;

    // program labels
    localparam logic [UPC_W-1:0] ST_NONE  = 5'd0;
    localparam logic [UPC_W-1:0] ST_GLIDE = 5'd12;
    localparam logic [UPC_W-1:0] ST_EMIT  = 5'd16;
    localparam logic [UPC_W-1:0] ST_ZERO  = 5'd17;

    typedef struct packed {
        logic [3:0]  channel;
        logic [6:0]  mod_amount;
        logic [15:0] mod_speed;
        logic        mod_kind;
        logic        porta_restart;
        logic [15:0] porta_speed;
        logic [6:0]  start_note;
        logic [6:0]  target_note;
    } t_in_req;

    typedef struct packed {
        logic signed [7:0] lfo_value;
        logic [1:0]        pitch_action;
        logic [6:0]        bend_percent;
        logic signed [7:0] pitch_span;
        logic              tremolo_on;
    } t_out_req;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } t_ucode;

    function automatic t_ucode f_ucode(input logic [UPC_W-1:0] addr);
        t_ucode w;
        unique case (addr)
            5'd0:    w = '{OP_NOP,       C_BAD_CH,     ST_ZERO};
            5'd1:    w = '{OP_NOP,       C_LFO_OFF,    ST_GLIDE};
            5'd2:    w = '{OP_DIV_POS,   C_NEXT,       ST_NONE};
            5'd3:    w = '{OP_NOP,       C_WAIT_DIV,   ST_NONE};
            5'd4:    w = '{OP_SAVE_POS,  C_NEXT,       ST_NONE};
            5'd5:    w = '{OP_HALF,      C_NEXT,       ST_NONE};
            5'd6:    w = '{OP_DIV_QTR,   C_NEXT,       ST_NONE};
            5'd7:    w = '{OP_NOP,       C_WAIT_DIV,   ST_NONE};
            5'd8:    w = '{OP_DIV_INQ,   C_NEXT,       ST_NONE};
            5'd9:    w = '{OP_NOP,       C_WAIT_DIV,   ST_NONE};
            5'd10:   w = '{OP_MUL_MAG,   C_NEXT,       ST_NONE};
            5'd11:   w = '{OP_SAVE_LFO,  C_NEXT,       ST_NONE};
            5'd12:   w = '{OP_GLIDE,     C_GLIDE_SKIP, ST_EMIT};
            5'd13:   w = '{OP_DIV_PCT,   C_NEXT,       ST_NONE};
            5'd14:   w = '{OP_NOP,       C_WAIT_DIV,   ST_NONE};
            5'd15:   w = '{OP_SAVE_PCT,  C_NEXT,       ST_NONE};
            5'd16:   w = '{OP_EMIT,      C_OUT_WAIT,   ST_NONE};
            5'd17:   w = '{OP_EMIT_ZERO, C_OUT_WAIT,   ST_NONE};
            default: w = '{OP_NOP,       C_END,        ST_NONE};
        endcase
        return w;
    endfunction

endpackage

### rtl/lfo_portamento_effect_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_portamento_effect_engine
// Per-channel triangle LFO (vibrato / tremolo) and portamento, run by a
// microcoded sequencer around one shared restoring divider.
// ----------------------------------------------------------------------------
// One request is one refresh tick of one channel. The block works on one
// request at a time: the result register is loaded once the program for the
// request has run, and waits while a stalled earlier result still holds it.
// The time is set by the 23-iteration divider: a tick with the LFO on divides
// three times (phase modulo period, phase modulo quarter period, triangle
// slope), a glide that runs on with a nonzero duration divides once more for
// its percent, and the depth scaling is a reciprocal multiply. A channel out
// of range is answered with an all-zero result and no division.
// A new request is taken as soon as the previous one has been placed in the
// result register, even while that result is still stalled.
module lfo_portamento_effect_engine
    import lfope_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out
);

    logic [7:0]           r_refresh_step;
    logic [15:0]          r_phase [CHANNELS];
    logic [15:0]          r_glide [CHANNELS];

    logic                 r_busy;
    logic [UPC_W-1:0]     r_upc;
    logic [UPC_W-1:0]     n_upc;
    t_in_req              r_in;
    t_ucode               uc;

    logic                 r_out_valid;
    t_out_req             r_out;

    logic [DIV_W-1:0]     r_dq;
    logic [15:0]          r_rem;
    logic [15:0]          r_dvs;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dvd;
    logic [15:0]          div_dvs;
    logic [16:0]          div_trial;
    logic                 div_ge;

    logic [15:0]          r_pos;
    logic [15:0]          r_h;
    logic                 r_neg;
    logic                 r_fall;
    logic [13:0]          r_prod;
    logic signed [7:0]    r_lfo;
    logic [1:0]           r_action;
    logic [6:0]           r_pct;
    logic [15:0]          r_gpos;

    logic [CH_IDX_W-1:0]  ch_idx;
    logic                 bad_ch;
    logic                 lfo_off;
    logic [14:0]          half;
    logic [13:0]          quarter;
    logic [15:0]          h1;
    logic [15:0]          h2;
    logic [6:0]           tri_mag;
    logic [26:0]          mag_scaled;
    logic [6:0]           mag;
    logic [15:0]          gp;
    logic [16:0]          gpos;
    logic                 g_idle;
    logic                 g_end;
    logic                 g_skip;
    logic                 out_free;
    logic                 take_in;
    logic                 emit;

    assign ch_idx   = CH_IDX_W'(r_in.channel);
    assign bad_ch   = CH_CMP_W'(r_in.channel) >= CH_CMP_W'(CHANNELS);
    assign lfo_off  = (r_in.mod_amount == '0) || (r_in.mod_speed < MIN_PERIOD);
    assign half     = r_in.mod_speed[15:1];
    assign quarter  = r_in.mod_speed[15:2];
    assign h1       = (r_rem >= {1'b0, half}) ? r_rem - {1'b0, half} : r_rem;
    assign h2       = (r_h >= {1'b0, half}) ? r_h - {1'b0, half} : r_h;
    assign tri_mag  = r_fall ? PCT_SCALE - r_dq[6:0] : r_dq[6:0];
    assign mag_scaled = 27'(r_prod) * 27'(MAG_RECIP);
    assign mag      = mag_scaled[MAG_SHIFT +: 7];

    assign gp       = r_in.porta_restart ? '0 : r_glide[ch_idx];
    assign gpos     = {1'b0, gp} + {9'b0, r_refresh_step};
    assign g_idle   = gp == GLIDE_IDLE;
    assign g_end    = gpos > {1'b0, r_in.porta_speed};
    assign g_skip   = g_idle || g_end || (r_in.porta_speed == '0);

    assign out_free = !r_out_valid || !i_out_stall;
    assign take_in  = !r_busy && i_in_valid;
    assign uc       = f_ucode(r_upc);
    assign emit     = r_busy && (uc.op == OP_EMIT || uc.op == OP_EMIT_ZERO) && out_free;

    assign div_trial = {r_rem, r_dq[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_dvs};

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = r_in.mod_speed;
        if (r_busy) begin
            unique case (uc.op)
                OP_DIV_POS: begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(r_phase[ch_idx]) + DIV_W'(r_refresh_step);
                    div_dvs   = r_in.mod_speed;
                end
                OP_DIV_QTR: begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(r_pos);
                    div_dvs   = 16'(quarter);
                end
                OP_DIV_INQ: begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(r_rem) * DIV_W'(PCT_SCALE);
                    div_dvs   = 16'(quarter);
                end
                OP_DIV_PCT: begin
                    div_start = 1'b1;
                    div_dvd   = DIV_W'(r_gpos) * DIV_W'(PCT_SCALE);
                    div_dvs   = r_in.porta_speed;
                end
                default: begin
                    div_start = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_upc = r_upc + 1'b1;
        unique case (uc.cond)
            C_NEXT:       n_upc = r_upc + 1'b1;
            C_WAIT_DIV:   n_upc = (r_div_cnt != '0) ? r_upc : r_upc + 1'b1;
            C_BAD_CH:     n_upc = bad_ch ? uc.target : r_upc + 1'b1;
            C_LFO_OFF:    n_upc = lfo_off ? uc.target : r_upc + 1'b1;
            C_GLIDE_SKIP: n_upc = g_skip ? uc.target : r_upc + 1'b1;
            C_OUT_WAIT:   n_upc = out_free ? '0 : r_upc;
            default:      n_upc = '0;
        endcase
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_upc          <= '0;
            r_out_valid    <= 1'b0;
            r_div_cnt      <= '0;
            r_refresh_step <= 8'd1;
            for (int i = 0; i < CHANNELS; i++) begin
                r_phase[i] <= '0;
                r_glide[i] <= GLIDE_IDLE;
            end
        end else begin
            if (i_cfg_we) begin
                r_refresh_step <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (div_start) begin
                r_div_cnt <= DIV_CNT_W'(DIV_W);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (take_in) begin
                r_busy <= 1'b1;
                r_upc  <= '0;
            end else if (r_busy) begin
                r_upc <= n_upc;
                if (uc.cond == C_END || (uc.cond == C_OUT_WAIT && out_free)) begin
                    r_busy <= 1'b0;
                end
                if (uc.op == OP_SAVE_POS) begin
                    r_phase[ch_idx] <= r_rem;
                end
                if (uc.op == OP_GLIDE && !g_idle) begin
                    r_glide[ch_idx] <= g_end ? GLIDE_IDLE : gpos[15:0];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in  <= i_in;
            r_lfo <= '0;
            r_pct <= '0;
        end
        if (div_start) begin
            r_dq  <= div_dvd;
            r_rem <= '0;
            r_dvs <= div_dvs;
        end else if (r_div_cnt != '0) begin
            r_dq  <= {r_dq[DIV_W-2:0], div_ge};
            r_rem <= div_ge ? 16'(div_trial - {1'b0, r_dvs}) : div_trial[15:0];
        end
        if (r_busy) begin
            unique case (uc.op)
                OP_SAVE_POS: begin
                    r_pos <= r_rem;
                    r_neg <= r_rem >= {1'b0, half};
                    r_h   <= h1;
                end
                OP_HALF: begin
                    r_fall <= h2 >= {2'b0, quarter};
                end
                OP_MUL_MAG: begin
                    r_prod <= 14'(tri_mag) * 14'(r_in.mod_amount);
                end
                OP_SAVE_LFO: begin
                    r_lfo <= r_neg ? -$signed({1'b0, mag})
                                   : $signed({1'b0, mag});
                end
                OP_GLIDE: begin
                    r_gpos <= gpos[15:0];
                    if (g_idle) begin
                        r_action <= (r_in.mod_amount != '0 && !r_in.mod_kind)
                                    ? ACT_VIBRATO : ACT_NONE;
                    end else if (g_end) begin
                        r_action <= ACT_FINISH;
                    end else begin
                        r_action <= ACT_GLIDE;
                        if (r_in.porta_speed == '0) begin
                            r_pct <= PCT_SCALE;
                        end
                    end
                end
                OP_SAVE_PCT: begin
                    r_pct <= r_dq[6:0];
                end
                OP_EMIT: begin
                    if (out_free) begin
                        r_out.lfo_value    <= r_lfo;
                        r_out.pitch_action <= r_action;
                        r_out.bend_percent <= r_pct;
                        r_out.pitch_span   <= $signed({1'b0, r_in.target_note})
                                            - $signed({1'b0, r_in.start_note});
                        r_out.tremolo_on   <= (r_in.mod_amount != '0) && r_in.mod_kind;
                    end
                end
                OP_EMIT_ZERO: begin
                    if (out_free) begin
                        r_out <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> !div_start)
        else $error("divider restarted while running");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_in_stall)
        else $error("request taken while a tick is in progress");

    a_emit_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("result raised without a tick in progress");

endmodule
